// ===== src/a2si_pkg.sv =====
package a2si_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned DIGIT_W     = 5;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 72;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NUL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TRAILING = 3'd4;

   // digit code for a byte that is no digit of any base
   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   // classified text byte as it travels through the queue
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               nul;
      logic               space;
      logic               plus;
      logic               minus;
      logic               letter_b;
      logic               letter_x;
      logic               last;
   } class_type;

   typedef enum logic [6:0] {
      PH_LEAD   = 7'b0000001,
      PH_SIGNED = 7'b0000010,
      PH_ZERO   = 7'b0000100,
      PH_ZEROX  = 7'b0001000,
      PH_BINPFX = 7'b0010000,
      PH_DIGITS = 7'b0100000,
      PH_TAIL   = 7'b1000000
   } phase_type;

   // parse outcome handed to the result stage
   typedef struct packed {
      logic [VALUE_W-1:0]  acc;
      logic                ovf;
      logic                neg;
      logic [STATUS_W-1:0] status;
   } fin_type;

endpackage

// ===== src/a2si_front.sv =====
module a2si_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [a2si_pkg::CHAR_W-1:0] char_byte,
   input  logic                       last_byte,
   output logic                       push_valid,
   input  logic                       push_ready,
   output a2si_pkg::class_type        push_entry
);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LB    = 8'h62;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] TEN        = 8'd10;

   logic [7:0] offset;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      offset = 8'd0;
      push_entry.digit = a2si_pkg::DIGIT_NONE;
      if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE) begin
         offset = char_byte - CHAR_ZERO;
         push_entry.digit = offset[a2si_pkg::DIGIT_W-1:0];
      end else if (char_byte >= CHAR_LA && char_byte <= CHAR_LF) begin
         offset = char_byte - CHAR_LA + TEN;
         push_entry.digit = offset[a2si_pkg::DIGIT_W-1:0];
      end else if (char_byte >= CHAR_UA && char_byte <= CHAR_UF) begin
         offset = char_byte - CHAR_UA + TEN;
         push_entry.digit = offset[a2si_pkg::DIGIT_W-1:0];
      end
      push_entry.nul      = (char_byte == 8'd0);
      push_entry.space    = (char_byte == CHAR_SPACE) ||
                            (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);
      push_entry.plus     = (char_byte == CHAR_PLUS);
      push_entry.minus    = (char_byte == CHAR_MINUS);
      push_entry.letter_b = (char_byte == CHAR_LB);
      push_entry.letter_x = (char_byte == CHAR_LX) || (char_byte == CHAR_UX);
      push_entry.last     = last_byte;
   end

endmodule

// ===== src/a2si_queue.sv =====
module a2si_queue #(
   parameter int unsigned DEPTH = a2si_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  a2si_pkg::class_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output a2si_pkg::class_type pop_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   a2si_pkg::class_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/a2si_back.sv =====
module a2si_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wide_result,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  a2si_pkg::class_type            pop_entry,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [a2si_pkg::VALUE_W-1:0]   value,
   output logic [a2si_pkg::STATUS_W-1:0]  status
);

   localparam int unsigned VW = a2si_pkg::VALUE_W;
   localparam int unsigned PW = a2si_pkg::VALUE_W + 5;
   localparam logic [VW-1:0] LIMIT_WIDE   = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] LIMIT_NARROW = 64'h0000_0000_7FFF_FFFF;

   function automatic logic [a2si_pkg::STATUS_W-1:0] note_status(
      input logic [a2si_pkg::STATUS_W-1:0] cur,
      input logic [a2si_pkg::STATUS_W-1:0] code
   );
      return (cur == a2si_pkg::STATUS_OK || code < cur) ? code : cur;
   endfunction

   function automatic logic [a2si_pkg::DIGIT_W-1:0] radix_size(input a2si_pkg::radix_type rx);
      logic [a2si_pkg::DIGIT_W-1:0] r;
      case (rx)
         a2si_pkg::RADIX_DEC: r = 5'd10;
         a2si_pkg::RADIX_OCT: r = 5'd8;
         a2si_pkg::RADIX_BIN: r = 5'd2;
         a2si_pkg::RADIX_HEX: r = 5'd16;
         default:             r = 5'd10;
      endcase
      return r;
   endfunction

   a2si_pkg::phase_type           phase_ff, phase_in;
   logic [VW-1:0]                 acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic                          neg_ff, neg_in;
   a2si_pkg::radix_type           radix_ff, radix_in;
   logic [a2si_pkg::STATUS_W-1:0] sticky_ff, sticky_in;

   a2si_pkg::fin_type             fin_ff, fin_in;
   logic                          fin_valid_ff, fin_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                 rsp_value_ff, rsp_value_in;
   logic [a2si_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                          fin_move, fin_free, pop;
   a2si_pkg::radix_type           step_radix;
   logic [PW-1:0]                 scaled, product;
   logic                          take, start;
   logic [VW-1:0]                 limit, limit_neg;

   assign fin_move  = fin_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign fin_free  = !fin_valid_ff || fin_move;
   assign pop_ready = !pop_entry.last || fin_free;
   assign pop       = pop_valid && pop_ready;

   // shift-add digit step; the carry bits above the word flag overflow
   assign step_radix = (phase_ff == a2si_pkg::PH_ZERO) ? a2si_pkg::RADIX_OCT : radix_ff;

   always_comb begin
      case (step_radix)
         a2si_pkg::RADIX_DEC: scaled = {2'b00, acc_ff, 3'b000} + {4'b0000, acc_ff, 1'b0};
         a2si_pkg::RADIX_OCT: scaled = {2'b00, acc_ff, 3'b000};
         a2si_pkg::RADIX_BIN: scaled = {4'b0000, acc_ff, 1'b0};
         a2si_pkg::RADIX_HEX: scaled = {1'b0, acc_ff, 4'b0000};
         default:             scaled = {5'b00000, acc_ff};
      endcase
      product = scaled + PW'(pop_entry.digit);
   end

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      sticky_in    = sticky_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_move;
      take         = 1'b0;
      start        = 1'b0;
      if (pop) begin
         if (pop_entry.nul) begin
            sticky_in = note_status(sticky_in, a2si_pkg::STATUS_NUL);
            phase_in  = a2si_pkg::PH_TAIL;
         end else begin
            case (phase_ff)
               a2si_pkg::PH_LEAD: begin
                  if (pop_entry.space) begin
                     phase_in = a2si_pkg::PH_LEAD;
                  end else if (pop_entry.plus || pop_entry.minus) begin
                     neg_in   = pop_entry.minus;
                     phase_in = a2si_pkg::PH_SIGNED;
                  end else begin
                     start = 1'b1;
                  end
               end
               a2si_pkg::PH_SIGNED: start = 1'b1;
               a2si_pkg::PH_ZERO: begin
                  if (pop_entry.letter_b) begin
                     radix_in = a2si_pkg::RADIX_BIN;
                     phase_in = a2si_pkg::PH_BINPFX;
                  end else if (pop_entry.letter_x) begin
                     radix_in = a2si_pkg::RADIX_HEX;
                     phase_in = a2si_pkg::PH_ZEROX;
                  end else begin
                     radix_in = a2si_pkg::RADIX_OCT;
                     phase_in = a2si_pkg::PH_DIGITS;
                     take     = 1'b1;
                  end
               end
               a2si_pkg::PH_ZEROX: begin
                  if (pop_entry.digit < 5'd16) begin
                     phase_in = a2si_pkg::PH_DIGITS;
                     take     = 1'b1;
                  end else begin
                     sticky_in = note_status(sticky_in, a2si_pkg::STATUS_TRAILING);
                     phase_in  = a2si_pkg::PH_TAIL;
                  end
               end
               a2si_pkg::PH_BINPFX: begin
                  if (pop_entry.digit < 5'd2) begin
                     phase_in = a2si_pkg::PH_DIGITS;
                     take     = 1'b1;
                  end else begin
                     sticky_in = note_status(sticky_in, a2si_pkg::STATUS_INVALID);
                     phase_in  = a2si_pkg::PH_TAIL;
                  end
               end
               a2si_pkg::PH_DIGITS: take = 1'b1;
               default: phase_in = a2si_pkg::PH_TAIL;
            endcase
            if (start) begin
               if (pop_entry.digit == 5'd0) begin
                  acc_in   = '0;
                  phase_in = a2si_pkg::PH_ZERO;
               end else if (pop_entry.digit < 5'd10) begin
                  acc_in   = VW'(pop_entry.digit);
                  radix_in = a2si_pkg::RADIX_DEC;
                  phase_in = a2si_pkg::PH_DIGITS;
               end else begin
                  sticky_in = note_status(sticky_in, a2si_pkg::STATUS_INVALID);
                  phase_in  = a2si_pkg::PH_TAIL;
               end
            end
            if (take) begin
               if (pop_entry.digit >= radix_size(step_radix)) begin
                  sticky_in = note_status(sticky_in, a2si_pkg::STATUS_TRAILING);
                  phase_in  = a2si_pkg::PH_TAIL;
               end else if (product[PW-1:VW] != '0) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = product[VW-1:0];
               end
            end
         end
         if (pop_entry.last) begin
            // a string that stops inside the prefix never reached a digit
            if (phase_in == a2si_pkg::PH_LEAD || phase_in == a2si_pkg::PH_SIGNED ||
                phase_in == a2si_pkg::PH_BINPFX) begin
               sticky_in = note_status(sticky_in, a2si_pkg::STATUS_INVALID);
            end else if (phase_in == a2si_pkg::PH_ZEROX) begin
               sticky_in = note_status(sticky_in, a2si_pkg::STATUS_TRAILING);
            end
            fin_in.acc    = acc_in;
            fin_in.ovf    = ovf_in;
            fin_in.neg    = neg_in;
            fin_in.status = sticky_in;
            fin_valid_in  = 1'b1;
            phase_in      = a2si_pkg::PH_LEAD;
            acc_in        = '0;
            ovf_in        = 1'b0;
            neg_in        = 1'b0;
            radix_in      = a2si_pkg::RADIX_DEC;
            sticky_in     = a2si_pkg::STATUS_OK;
         end
      end
   end

   // range check and sign against the selected width
   assign limit     = wide_result ? LIMIT_WIDE : LIMIT_NARROW;
   assign limit_neg = limit + 1'b1;

   always_comb begin
      rsp_value_in  = '0;
      rsp_status_in = fin_ff.status;
      if (fin_ff.status != a2si_pkg::STATUS_NUL && fin_ff.status != a2si_pkg::STATUS_INVALID) begin
         if (fin_ff.neg) begin
            if (fin_ff.ovf || fin_ff.acc > limit_neg) begin
               rsp_status_in = a2si_pkg::STATUS_RANGE;
               rsp_value_in  = '0 - limit_neg;
            end else begin
               rsp_value_in = '0 - fin_ff.acc;
            end
         end else begin
            if (fin_ff.ovf || fin_ff.acc > limit) begin
               rsp_status_in = a2si_pkg::STATUS_RANGE;
               rsp_value_in  = limit;
            end else begin
               rsp_value_in = fin_ff.acc;
            end
         end
      end
      rsp_valid_in = fin_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= a2si_pkg::PH_LEAD;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         radix_ff     <= a2si_pkg::RADIX_DEC;
         sticky_ff    <= a2si_pkg::STATUS_OK;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         neg_ff       <= neg_in;
         radix_ff     <= radix_in;
         sticky_ff    <= sticky_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      if (fin_move) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign value     = rsp_value_ff;
   assign status    = rsp_status_ff;

endmodule

// ===== src/ascii_to_signed_integer_core.sv =====
// Streaming text-to-integer parser.
// req_*: one text byte per word, req_tlast marks the last byte of a string.
// rsp_*: one word per string, carrying the signed value and a status code
//   (ok, embedded NUL, invalid start, out of range, trailing characters).
// csr_*: one-bit write channel; csr_data = 1 selects the 64-bit signed range,
//   0 the 32-bit range (result sign-extended). Reset value is 1. Write it
//   only while no string is in flight.
// Throughput: one byte per cycle while the receiver keeps up, set by the
//   shift-add digit step in the back end; strings follow each other without gaps.
// The last byte of a string passes the queue, then the parse step, then the
//   range stage, before its result word shows on rsp_tvalid.
// A classifier front end feeds a QUEUE_DEPTH-word queue; the parser pops it.
// When the receiver stalls, the result register holds, the queue fills and
// req_tready drops once it is full; no word is lost or repeated.
// Reset clears the queue, the parse state and the result valid flags and sets
// the range select back to 64 bits.
module ascii_to_signed_integer_core #(
   parameter int unsigned QUEUE_DEPTH = a2si_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [a2si_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] char_byte
   input  logic                               req_tlast,   // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [a2si_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [63:0] value, [66:64] status
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data     // wide_result
);

   logic                          wide_ff, wide_in;
   logic                          push_valid, push_ready;
   a2si_pkg::class_type           push_entry;
   logic                          pop_valid, pop_ready;
   a2si_pkg::class_type           pop_entry;
   logic [a2si_pkg::VALUE_W-1:0]  value;
   logic [a2si_pkg::STATUS_W-1:0] status;

   // range select register; always ready to take a write
   assign csr_ready = 1'b1;
   assign wide_in   = (csr_valid && csr_ready) ? csr_data : wide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b1;
      end else begin
         wide_ff <= wide_in;
      end
   end

   // classify each byte as it arrives
   a2si_front u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .char_byte  (req_tdata[a2si_pkg::CHAR_W-1:0]),
      .last_byte  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decouple the front end from parser stalls
   a2si_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // parse, range-check and hold the result word
   a2si_back u_back (
      .clock       (clock),
      .reset       (reset),
      .wide_result (wide_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .value       (value),
      .status      (status)
   );

   assign rsp_tdata = {
      {(a2si_pkg::RSP_DATA_W - a2si_pkg::VALUE_W - a2si_pkg::STATUS_W){1'b0}},
      status, value};

`ifndef SYNTH
   // status codes stay within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status <= a2si_pkg::STATUS_TRAILING))
      else $error("result status code out of range");

   // a NUL or invalid string always carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == a2si_pkg::STATUS_NUL || status == a2si_pkg::STATUS_INVALID)
      |-> (value == '0))
      else $error("error status with nonzero value");

   // a range error saturates to one of the signed limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == a2si_pkg::STATUS_RANGE) |->
      (value == 64'h7FFF_FFFF_FFFF_FFFF || value == 64'h8000_0000_0000_0000 ||
       value == 64'h0000_0000_7FFF_FFFF || value == 64'hFFFF_FFFF_8000_0000))
      else $error("range error without saturated value");

   // in 32-bit mode every result is a sign-extended 32-bit value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !wide_ff |->
      (value[63:31] == '0 || value[63:31] == '1))
      else $error("narrow result not sign-extended");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the streaming text-to-integer parser.
// Text strings are split into one byte per word and pushed through the
// request stream. A scoreboard model tracks the parse state byte by byte and
// queues the number each string must produce. The monitor compares every
// response word against the oldest queued number.
module tb_top;
   import a2si_pkg::*;

   // ASCII codes the parser reacts to
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_ONE    = "1";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_LOW_A  = "a";
   localparam logic [7:0] CH_LOW_F  = "f";
   localparam logic [7:0] CH_UP_A   = "A";
   localparam logic [7:0] CH_UP_F   = "F";
   localparam logic [7:0] CH_LOW_B  = "b";
   localparam logic [7:0] CH_LOW_X  = "x";
   localparam logic [7:0] CH_UP_X   = "X";

   localparam logic [VALUE_W-1:0] LIMIT_64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] LIMIT_32 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // random byte budget per traffic phase
   localparam int unsigned PHASE_BYTES = 340;
   // cycles to let the result pipeline settle before a range change
   localparam int unsigned SETTLE_CYCLES = 6;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } number_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // [7:0] char_byte
   logic                  req_tlast = 1'b0;   // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [63:0] value, [66:64] status
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_data = 1'b1;    // wide_result

   ascii_to_signed_integer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and scoreboard storage
   text_word_type text_bytes[$];        // words waiting for the driver
   logic [7:0]    text_buf[$];          // string under construction
   number_type    pending_numbers[$];   // numbers still owed by the block
   int unsigned   queued_bytes = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   sender_gap_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   logic          req_taken = 1'b0;     // request word accepted at the last rising edge

   // Scoreboard copy of the parse state
   phase_type         scan_phase = PH_LEAD;
   radix_type         scan_radix = RADIX_DEC;
   logic [VALUE_W-1:0] magnitude = '0;
   logic              magnitude_ovf = 1'b0;
   logic              minus_seen = 1'b0;
   logic [STATUS_W-1:0] held_status = STATUS_OK;
   logic              wide_mode = 1'b1;

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard model
   // ---------------------------------------------------------------------
   function automatic void clear_scan();
      scan_phase    = PH_LEAD;
      scan_radix    = RADIX_DEC;
      magnitude     = '0;
      magnitude_ovf = 1'b0;
      minus_seen    = 1'b0;
      held_status   = STATUS_OK;
   endfunction

   // keep the highest-priority status seen so far (lower code wins)
   function automatic void post_status(logic [STATUS_W-1:0] s);
      if (held_status == STATUS_OK || s < held_status) begin
         held_status = s;
      end
   endfunction

   function automatic logic [DIGIT_W-1:0] digit_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return DIGIT_W'(c - CH_LOW_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_F) return DIGIT_W'(c - CH_UP_A + 8'd10);
      return DIGIT_NONE;
   endfunction

   function automatic logic [VALUE_W-1:0] radix_value(radix_type r);
      case (r)
         RADIX_OCT: return 64'd8;
         RADIX_BIN: return 64'd2;
         RADIX_HEX: return 64'd16;
         default:   return 64'd10;
      endcase
   endfunction

   // shift one digit into the magnitude; a byte that is no digit of the radix ends the number
   function automatic void take_digit(logic [7:0] c);
      logic [VALUE_W-1:0] step_radix;
      logic [VALUE_W-1:0] d;
      step_radix = radix_value(scan_radix);
      d = VALUE_W'(digit_of(c));
      if (d >= step_radix) begin
         post_status(STATUS_TRAILING);
         scan_phase = PH_TAIL;
         return;
      end
      // hold the magnitude once it would pass 2^64-1, just flag it
      if (magnitude > (ALL_ONES - d) / step_radix) begin
         magnitude_ovf = 1'b1;
      end else begin
         magnitude = magnitude * step_radix + d;
      end
   endfunction

   function automatic void start_number(logic [7:0] c);
      if (c == CH_ZERO) begin
         magnitude  = '0;
         scan_phase = PH_ZERO;
      end else if (c >= CH_ONE && c <= CH_NINE) begin
         magnitude  = VALUE_W'(c - CH_ZERO);
         scan_radix = RADIX_DEC;
         scan_phase = PH_DIGITS;
      end else begin
         post_status(STATUS_INVALID);
         scan_phase = PH_TAIL;
      end
   endfunction

   // close the string: resolve status, saturate, queue the owed number
   function automatic void finish_number();
      logic [VALUE_W-1:0] lim;
      number_type         n;
      if (scan_phase inside {PH_LEAD, PH_SIGNED, PH_BINPFX}) begin
         post_status(STATUS_INVALID);
      end else if (scan_phase == PH_ZEROX) begin
         post_status(STATUS_TRAILING);
      end
      n.status = held_status;
      n.value  = '0;
      if (held_status != STATUS_NUL && held_status != STATUS_INVALID) begin
         lim = wide_mode ? LIMIT_64 : LIMIT_32;
         if (minus_seen) begin
            // the magnitude lim+1 with a minus sign is the exact minimum
            if (magnitude_ovf || magnitude > lim + 64'd1) begin
               n.status = STATUS_RANGE;
               n.value  = 64'd0 - (lim + 64'd1);
            end else begin
               n.value = 64'd0 - magnitude;
            end
         end else begin
            if (magnitude_ovf || magnitude > lim) begin
               n.status = STATUS_RANGE;
               n.value  = lim;
            end else begin
               n.value = magnitude;
            end
         end
      end
      pending_numbers.push_back(n);
      clear_scan();
   endfunction

   function automatic void parse_char(logic [7:0] c, logic last);
      if (c == CH_NUL) begin
         // an embedded NUL poisons the rest of the string
         post_status(STATUS_NUL);
         scan_phase = PH_TAIL;
      end else begin
         case (scan_phase)
            PH_LEAD: begin
               if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                  // skip leading whitespace
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  minus_seen = (c == CH_MINUS);
                  scan_phase = PH_SIGNED;
               end else begin
                  start_number(c);
               end
            end
            PH_SIGNED: start_number(c);
            PH_ZERO: begin
               if (c == CH_LOW_B) begin
                  scan_radix = RADIX_BIN;
                  scan_phase = PH_BINPFX;
               end else if (c == CH_LOW_X || c == CH_UP_X) begin
                  scan_radix = RADIX_HEX;
                  scan_phase = PH_ZEROX;
               end else begin
                  // a leading zero followed by anything else means octal
                  scan_radix = RADIX_OCT;
                  scan_phase = PH_DIGITS;
                  take_digit(c);
               end
            end
            PH_ZEROX: begin
               // hex prefix with no hex digit parses as zero with a tail
               if (digit_of(c) < DIGIT_NONE) begin
                  scan_phase = PH_DIGITS;
                  take_digit(c);
               end else begin
                  post_status(STATUS_TRAILING);
                  scan_phase = PH_TAIL;
               end
            end
            PH_BINPFX: begin
               // binary prefix must be followed by a bit
               if (c == CH_ZERO || c == CH_ONE) begin
                  scan_phase = PH_DIGITS;
                  take_digit(c);
               end else begin
                  post_status(STATUS_INVALID);
                  scan_phase = PH_TAIL;
               end
            end
            PH_DIGITS: take_digit(c);
            default: ;
         endcase
      end
      if (last) finish_number();
   endfunction

   // ---------------------------------------------------------------------
   // String construction
   // ---------------------------------------------------------------------
   task automatic add_chars(string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   // move the string under construction to the driver, tag its last byte
   task automatic commit_text();
      text_word_type w;
      for (int i = 0; i < text_buf.size(); i++) begin
         w.ch   = text_buf[i];
         w.last = (i == text_buf.size() - 1);
         text_bytes.push_back(w);
      end
      queued_bytes += text_buf.size();
      text_buf.delete();
   endtask

   task automatic push_str(string s);
      add_chars(s);
      commit_text();
   endtask

   // Mostly well-formed numbers with random content and boundary-heavy
   // magnitudes; the rest is raw noise, cut-off strings, tails and NULs.
   task automatic queue_random_text();
      int unsigned        pick;
      int unsigned        k;
      logic [VALUE_W-1:0] mag;
      string              digits;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // raw noise over the full byte range
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         commit_text();
         return;
      end
      // leading whitespace, space or one of TAB..CR
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1)) begin
            k = $urandom_range(8, 13);
            text_buf.push_back(k == 8 ? CH_SPACE : 8'(k));
         end
      end
      case ($urandom_range(0, 2))
         0: text_buf.push_back(CH_PLUS);
         1: text_buf.push_back(CH_MINUS);
         default: ;
      endcase
      // magnitude: small, full width, or hugging a 32/63/64-bit boundary
      k = $urandom_range(0, 9);
      case (k)
         0, 1, 2, 3: mag = 64'($urandom_range(0, 1000));
         4, 5:       mag = {$urandom, $urandom};
         6:          mag = 64'h8000_0000 + 64'($urandom_range(0, 4)) - 64'd2;
         7:          mag = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3)) - 64'd2;
         8:          mag = ALL_ONES - 64'($urandom_range(0, 2));
         default:    mag = 64'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         add_chars($sformatf("%0d", mag));
      end else if (pick < 50) begin
         digits = $sformatf("%0o", mag);
         if ($urandom_range(0, 4) == 0) digits = {"00", digits};
         add_chars({"0", digits});
      end else if (pick < 70) begin
         digits = $sformatf("%0h", mag);
         if ($urandom_range(0, 1)) digits = digits.toupper();
         if ($urandom_range(0, 4) == 0) digits = {"000", digits};
         if ($urandom_range(0, 1)) begin
            add_chars({"0x", digits});
         end else begin
            add_chars({"0X", digits});
         end
      end else if (pick < 85) begin
         digits = $sformatf("%0b", mag);
         if ($urandom_range(0, 4) == 0) digits = {"0", digits};
         add_chars({"0b", digits});
      end else if (pick < 95) begin
         // long decimal of 20 to 25 digits that may run past 2^64-1
         digits = "1";
         repeat ($urandom_range(19, 24)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
         add_chars(digits);
      end else begin
         add_chars("0");
      end
      // trailing garbage
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      // cut the string short: reaches bare prefixes and lone signs
      if ($urandom_range(0, 99) < 8 && text_buf.size() > 1) begin
         text_buf = text_buf[0:$urandom_range(0, text_buf.size() - 2)];
      end
      if ($urandom_range(0, 99) < 3) begin
         text_buf[$urandom_range(0, text_buf.size() - 1)] = CH_NUL;
      end
      commit_text();
   endtask

   task automatic queue_random_phase();
      int unsigned start_count;
      start_count = queued_bytes;
      while (queued_bytes - start_count < PHASE_BYTES) queue_random_text();
   endtask

   // hold until every word is sent and every number has come back
   task automatic wait_idle();
      while (text_bytes.size() != 0 || req_tvalid || pending_numbers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_range(logic wide);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= wide;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wide_mode = wide;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Driver: advance the request word on the falling edge once the current
   // one is taken; drop valid on a random gap. Stall the receiver likewise.
   // ---------------------------------------------------------------------
   text_word_type next_word;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && (!req_tvalid || req_taken)) begin
         if (text_bytes.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
            next_word = text_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.ch;
            req_tlast  <= next_word.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: feed accepted request words to the model and check every
   // accepted response word against the oldest owed number.
   // ---------------------------------------------------------------------
   number_type          oldest;
   logic [VALUE_W-1:0]  got_value;
   logic [STATUS_W-1:0] got_status;

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            parse_char(req_tdata[CHAR_W-1:0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_value  = rsp_tdata[VALUE_W-1:0];
            got_status = rsp_tdata[VALUE_W+STATUS_W-1:VALUE_W];
            if (pending_numbers.size() == 0) begin
               report_mismatch($sformatf("unexpected word value %h status %0d",
                                         got_value, got_status));
            end else begin
               oldest = pending_numbers.pop_front();
               if (got_value !== oldest.value) begin
                  report_mismatch($sformatf("value got %h want %h", got_value, oldest.value));
               end
               if (got_status !== oldest.status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                                            got_status, oldest.status));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 64-bit range from reset, no idling: directed corners first
      push_str("0");
      push_str("-0");
      text_buf = {CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
      push_str("+42");
      push_str("9223372036854775807");
      push_str("-9223372036854775808");
      push_str("9223372036854775808");
      push_str("-9223372036854775809");
      push_str("18446744073709551616");
      push_str("0xFFFFFFFFFFFFFFFFF");
      push_str("   ");
      push_str("-");
      push_str("+x");
      push_str("0b1011");
      push_str("0b");
      push_str("0b2");
      push_str("0x1fA");
      push_str("0X");
      push_str("0xg");
      push_str("0755");
      push_str("089");
      push_str("12ab");
      add_chars("12");
      text_buf.push_back(CH_NUL);
      push_str("x");
      add_chars("z");
      text_buf.push_back(CH_NUL);
      commit_text();
      text_buf.push_back(8'hFF);
      commit_text();
      queue_random_phase();
      wait_idle();

      // 32-bit range, sender idles often
      write_range(1'b0);
      sender_gap_pct = 61;
      push_str("2147483647");
      push_str("2147483648");
      push_str("-2147483648");
      push_str("-2147483649");
      push_str("0x7fffffff");
      push_str("4294967296");
      queue_random_phase();
      wait_idle();

      // back to 64 bits, receiver stalls often
      write_range(1'b1);
      sender_gap_pct = 0;
      rsp_stall_pct  = 61;
      queue_random_phase();
      wait_idle();

      // 32 bits again with both sides idling
      write_range(1'b0);
      sender_gap_pct = 35;
      rsp_stall_pct  = 35;
      queue_random_phase();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("ascii_to_signed_integer_core test passed");
      end else begin
         $display("ascii_to_signed_integer_core test failed");
      end
      $finish;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      #5_000_000;
      $display("ascii_to_signed_integer_core test failed");
      $finish;
   end

endmodule
